@@ rtl/cop_pkg.sv @@
// Types and constants shared by the option parser modules.
package cop_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  MARKER_BYTE = 8'hFF;
   localparam logic [3:0]  NIBBLE_BAD  = 4'd15;
   localparam logic [3:0]  NIBBLE_EXT1 = 4'd13;
   localparam logic [3:0]  NIBBLE_EXT2 = 4'd14;
   localparam logic [15:0] EXT1_BIAS   = 16'd13;
   localparam logic [16:0] EXT2_BIAS   = 17'd269;

   typedef enum logic [2:0] {
      KIND_VALUE  = 3'd0,
      KIND_EMPTY  = 3'd1,
      KIND_MARKER = 3'd2,
      KIND_FORMAT = 3'd3,
      KIND_TRUNC  = 3'd4
   } kind_type;

   typedef enum logic [5:0] {
      PH_HEADER  = 6'b000001,
      PH_DEXT_HI = 6'b000010,
      PH_DEXT_LO = 6'b000100,
      PH_LEXT_HI = 6'b001000,
      PH_LEXT_LO = 6'b010000,
      PH_VALUE   = 6'b100000
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] option_number;
      logic [15:0] option_length;
      logic [7:0]  value_byte;
      logic [15:0] byte_index;
      logic        last_of_option;
   } res_type;

   typedef struct packed {
      logic    valid;
      res_type res;
   } push_type;

endpackage

@@ rtl/cop_front.sv @@
// Option header parser: tracks delta/length decoding and produces result words.
module cop_front
   import cop_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       start_of_options,
   input  logic       end_of_buffer,
   output push_type   push_a,
   output push_type   push_b
);

   phase_type   phase_ff, phase_in, phase_cur;
   logic [15:0] prev_number_ff, prev_number_in, prev_number_cur;
   logic [3:0]  delta_nibble_ff, delta_nibble_in, delta_nibble_cur;
   logic [3:0]  length_nibble_ff, length_nibble_in, length_nibble_cur;
   logic [7:0]  ext_high_ff, ext_high_in, ext_high_cur;
   logic [15:0] cur_length_ff, cur_length_in, cur_length_cur;
   logic [15:0] value_count_ff, value_count_in, value_count_cur;
   logic        stopped_ff, stopped_in, stopped_cur;

   logic        restart;
   logic [16:0] ext_sum;
   logic [15:0] short_sum;
   logic        delta_ok, len_ok;
   logic [15:0] delta_val, len_val;
   logic        prim_v, trunc_v, last_flag;
   res_type     prim, trunc;

   assign restart   = accept && start_of_options;
   assign ext_sum   = {1'b0, ext_high_cur, data_byte} + EXT2_BIAS;
   assign short_sum = {8'd0, data_byte} + EXT1_BIAS;

   always_comb begin
      phase_cur         = restart ? PH_HEADER : phase_ff;
      prev_number_cur   = restart ? 16'd0 : prev_number_ff;
      delta_nibble_cur  = restart ? 4'd0 : delta_nibble_ff;
      length_nibble_cur = restart ? 4'd0 : length_nibble_ff;
      ext_high_cur      = restart ? 8'd0 : ext_high_ff;
      cur_length_cur    = restart ? 16'd0 : cur_length_ff;
      value_count_cur   = restart ? 16'd0 : value_count_ff;
      stopped_cur       = restart ? 1'b0 : stopped_ff;

      phase_in         = phase_cur;
      prev_number_in   = prev_number_cur;
      delta_nibble_in  = delta_nibble_cur;
      length_nibble_in = length_nibble_cur;
      ext_high_in      = ext_high_cur;
      cur_length_in    = cur_length_cur;
      value_count_in   = value_count_cur;
      stopped_in       = stopped_cur;

      prim      = '0;
      trunc     = '0;
      prim_v    = 1'b0;
      trunc_v   = 1'b0;
      delta_ok  = 1'b0;
      delta_val = '0;
      len_ok    = 1'b0;
      len_val   = '0;
      last_flag = 1'b0;

      if (accept && !stopped_cur) begin
         case (phase_cur)
            PH_DEXT_HI: begin
               ext_high_in = data_byte;
               phase_in    = PH_DEXT_LO;
            end
            PH_DEXT_LO: begin
               delta_ok  = 1'b1;
               delta_val = (delta_nibble_cur == NIBBLE_EXT2) ? ext_sum[15:0] : short_sum;
            end
            PH_LEXT_HI: begin
               ext_high_in = data_byte;
               phase_in    = PH_LEXT_LO;
            end
            PH_LEXT_LO: begin
               if (length_nibble_cur == NIBBLE_EXT2) begin
                  if (ext_sum[16]) begin
                     // extended length beyond 16 bits
                     prim_v             = 1'b1;
                     prim.kind          = KIND_FORMAT;
                     prim.option_number = prev_number_cur;
                     stopped_in         = 1'b1;
                     phase_in           = PH_HEADER;
                  end else begin
                     len_ok  = 1'b1;
                     len_val = ext_sum[15:0];
                  end
               end else begin
                  len_ok  = 1'b1;
                  len_val = short_sum;
               end
            end
            PH_VALUE: begin
               last_flag           = (value_count_cur + 16'd1) == cur_length_cur;
               prim_v              = 1'b1;
               prim.kind           = KIND_VALUE;
               prim.option_number  = prev_number_cur;
               prim.option_length  = cur_length_cur;
               prim.value_byte     = data_byte;
               prim.byte_index     = value_count_cur;
               prim.last_of_option = last_flag;
               value_count_in      = value_count_cur + 16'd1;
               if (last_flag) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               cur_length_in = '0;
               if (data_byte == MARKER_BYTE) begin
                  prim_v             = 1'b1;
                  prim.kind          = KIND_MARKER;
                  prim.option_number = prev_number_cur;
                  stopped_in         = 1'b1;
                  phase_in           = PH_HEADER;
               end else begin
                  delta_nibble_in  = data_byte[7:4];
                  length_nibble_in = data_byte[3:0];
                  if (data_byte[7:4] == NIBBLE_BAD || data_byte[3:0] == NIBBLE_BAD) begin
                     prim_v             = 1'b1;
                     prim.kind          = KIND_FORMAT;
                     prim.option_number = prev_number_cur;
                     stopped_in         = 1'b1;
                     phase_in           = PH_HEADER;
                  end else if (data_byte[7:4] < NIBBLE_EXT1) begin
                     delta_ok  = 1'b1;
                     delta_val = {12'd0, data_byte[7:4]};
                  end else begin
                     phase_in = (data_byte[7:4] == NIBBLE_EXT2) ? PH_DEXT_HI : PH_DEXT_LO;
                  end
               end
            end
         endcase

         if (delta_ok) begin
            prev_number_in = prev_number_cur + delta_val;
            if (length_nibble_in < NIBBLE_EXT1) begin
               len_ok  = 1'b1;
               len_val = {12'd0, length_nibble_in};
            end else begin
               phase_in = (length_nibble_in == NIBBLE_EXT2) ? PH_LEXT_HI : PH_LEXT_LO;
            end
         end

         if (len_ok) begin
            cur_length_in  = len_val;
            value_count_in = '0;
            if (len_val == 16'd0) begin
               prim_v              = 1'b1;
               prim.kind           = KIND_EMPTY;
               prim.option_number  = prev_number_in;
               prim.last_of_option = 1'b1;
               phase_in            = PH_HEADER;
            end else begin
               phase_in = PH_VALUE;
            end
         end

         if (end_of_buffer && !stopped_in) begin
            trunc_v             = (phase_in != PH_HEADER);
            trunc.kind          = KIND_TRUNC;
            trunc.option_number = prev_number_in;
            trunc.option_length = cur_length_in;
            stopped_in          = 1'b1;
            phase_in            = PH_HEADER;
         end
      end
   end

   // compact: the truncation word takes slot a when the byte had no own result
   always_comb begin
      push_a.valid = prim_v || trunc_v;
      push_a.res   = prim_v ? prim : trunc;
      push_b.valid = prim_v && trunc_v;
      push_b.res   = trunc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         prev_number_ff   <= '0;
         delta_nibble_ff  <= '0;
         length_nibble_ff <= '0;
         ext_high_ff      <= '0;
         cur_length_ff    <= '0;
         value_count_ff   <= '0;
         stopped_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         prev_number_ff   <= prev_number_in;
         delta_nibble_ff  <= delta_nibble_in;
         length_nibble_ff <= length_nibble_in;
         ext_high_ff      <= ext_high_in;
         cur_length_ff    <= cur_length_in;
         value_count_ff   <= value_count_in;
         stopped_ff       <= stopped_in;
      end
   end

endmodule

@@ rtl/cop_queue.sv @@
// Result queue: takes up to two words a cycle from the parser, hands out one.
module cop_queue
   import cop_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push_a,
   input  push_type push_b,
   output logic     space_ok,
   output logic     out_valid,
   input  logic     out_ready,
   output res_type  out_res
);

   res_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  head_ff, head_in;
   logic [QUEUE_PTR_W-1:0]  tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic [QUEUE_PTR_W-1:0]  tail_b;
   logic                    pop;
   logic [QUEUE_CNT_W-1:0]  n_push;

   // room for the worst case of two words from one byte
   assign space_ok  = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_res   = mem_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign tail_b    = tail_ff + QUEUE_PTR_W'(push_a.valid);
   assign n_push    = QUEUE_CNT_W'(push_a.valid) + QUEUE_CNT_W'(push_b.valid);

   always_comb begin
      head_in  = head_ff + QUEUE_PTR_W'(pop);
      tail_in  = tail_ff + QUEUE_PTR_W'(n_push);
      count_in = count_ff + n_push - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_a.valid) begin
         mem_ff[tail_ff] <= push_a.res;
      end
      if (push_b.valid) begin
         mem_ff[tail_b] <= push_b.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/coap_option_parser_top.sv @@
// Top level of the CoAP option section parser with stream ports.
//
// Parses the option section one byte per cycle while req_tready is high: a
// byte accepted on the request side is decoded in the same cycle and its
// result words enter a four-word queue, so a word can be taken on the
// response side from the next cycle on. The output side drains one word a
// cycle while rsp_tready is high; a byte that gives a word of its own and
// also ends the buffer inside an option yields two words. req_tready drops
// while fewer than two queue slots are free. A byte with req_tuser set
// restarts parsing; after a marker, a format error or the buffer end, bytes
// give no words until such a restart.
module coap_option_parser_top
   import cop_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // start_of_options
   input  logic        req_tlast,  // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] option_number, [31:16] option_length, [39:32] value_byte,
   // [55:40] byte_index
   output logic [55:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,  // [2:0] kind
   output logic        rsp_tlast   // last_of_option
);

   push_type push_a, push_b;
   logic     space_ok;
   logic     accept;
   res_type  head;

   assign req_tready = space_ok;
   assign accept     = req_tvalid && space_ok;

   cop_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .data_byte        (req_tdata),
      .start_of_options (req_tuser),
      .end_of_buffer    (req_tlast),
      .push_a           (push_a),
      .push_b           (push_b)
   );

   cop_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .push_b    (push_b),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (head)
   );

   assign rsp_tdata = {head.byte_index, head.value_byte, head.option_length, head.option_number};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_option;

endmodule
